// ----- design/scalar_kalman_speed_filter_defines.svh -----
// assertion macros for the speed filter checker
`ifndef SCALAR_KALMAN_SPEED_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_SPEED_FILTER_DEFINES_SVH

// same-cycle implication
`define SKF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/skf_pkg.sv -----
package skf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SPEED_W    = 32;
  localparam int ERR_W      = 24;
  localparam int GAIN_OUT_W = 17;
  localparam int GAIN_W     = FRAC_BITS + 1;
  localparam int DEN_W      = ERR_W + 1;
  localparam int DIV_STEPS  = GAIN_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_ERR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST = 2'd2;

  localparam logic [ERR_W-1:0]          MEAS_ERR_RST = 24'd2621;
  localparam logic [ERR_W-1:0]          INIT_ERR_RST = 24'd26214;
  localparam logic signed [SPEED_W-1:0] INIT_EST_RST = 32'sd0;

  typedef struct packed {
    logic signed [SPEED_W-1:0] measured_speed;
    logic                      restart;
  } sample_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] estimated_speed;
    logic [GAIN_OUT_W-1:0]     gain;
    logic [ERR_W-1:0]          error_estimate;
  } result_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic mul;
    logic update;
    logic reload;
  } cmd_t;

endpackage

// ----- design/skf_ctrl.sv -----
module skf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          sample_valid,
  input  logic          restart,
  input  logic          result_ready,
  output logic          sample_ready,
  output logic          result_valid,
  output skf_pkg::cmd_t cmd
);
  import skf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_RLD  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_free;
  logic             accept;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_free     = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.start  = 1'b1;
          cnt_next   = '0;
          state_next = restart ? S_RLD : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RLD: begin
        if (out_free) begin
          cmd.reload = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.update || cmd.reload) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/skf_dp.sv -----
module skf_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  skf_pkg::cmd_t                      cmd,
  input  skf_pkg::sample_t                   sample,
  input  logic                               cfg_write,
  input  logic [skf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [skf_pkg::SPEED_W-1:0]        cfg_data,
  output skf_pkg::result_t                   result
);
  import skf_pkg::*;

  localparam int NUM_W = ERR_W + FRAC_BITS + 1;
  localparam int PE_W  = GAIN_W + SPEED_W + 2;
  localparam int PR_W  = GAIN_W + ERR_W;

  // configuration
  logic [ERR_W-1:0]          meas_err;
  logic [ERR_W-1:0]          init_err;
  logic signed [SPEED_W-1:0] init_est;

  // filter state
  logic signed [SPEED_W-1:0] est;
  logic [ERR_W-1:0]          err;

  // working registers
  logic signed [SPEED_W-1:0] meas;
  logic [DEN_W-1:0]          den;
  logic [DEN_W-1:0]          rem;
  logic [FRAC_BITS:0]        nlo;
  logic [GAIN_W-1:0]         quo;
  logic [GAIN_W-1:0]         gain_r;
  logic signed [PE_W-1:0]    pe;
  logic [PR_W-1:0]           pr;

  logic [DEN_W-1:0]          den_init;
  logic [NUM_W-1:0]          num;
  logic [DEN_W:0]            trial;
  logic [DEN_W:0]            trial_sub;
  logic [GAIN_W-1:0]         gain_sel;
  logic signed [SPEED_W:0]   diff;
  logic signed [PE_W-1:0]    sum;
  logic                      ovf;
  logic signed [SPEED_W-1:0] est_next;
  logic [PR_W-1:0]           err_wide;
  logic [ERR_W-1:0]          err_next;

  assign den_init  = {1'b0, err} + {1'b0, meas_err};
  assign num       = {1'b0, err, {FRAC_BITS{1'b0}}} + NUM_W'(den_init >> 1);
  assign trial     = {rem, nlo[FRAC_BITS]};
  assign trial_sub = trial - {1'b0, den};

  always_comb begin
    if (den == '0) begin
      gain_sel = '0;
    end else if (quo > GAIN_ONE) begin
      gain_sel = GAIN_ONE;
    end else begin
      gain_sel = quo;
    end
  end

  assign diff = (SPEED_W + 1)'(meas) - (SPEED_W + 1)'(est);

  // round half up toward plus infinity, then saturate
  assign sum = ((pe + PE_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS) + PE_W'(est);
  assign ovf = (sum[PE_W-1:SPEED_W-1] != '0) && (sum[PE_W-1:SPEED_W-1] != '1);

  always_comb begin
    if (ovf) begin
      est_next = sum[PE_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
    end else begin
      est_next = sum[SPEED_W-1:0];
    end
  end

  assign err_wide = (pr + PR_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign err_next = (err_wide > PR_W'(err)) ? err : err_wide[ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_err <= MEAS_ERR_RST;
      init_err <= INIT_ERR_RST;
      init_est <= INIT_EST_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MEAS_ERR: meas_err <= cfg_data[ERR_W-1:0];
        CFG_INIT_ERR: init_err <= cfg_data[ERR_W-1:0];
        CFG_INIT_EST: init_est <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= INIT_EST_RST;
      err <= INIT_ERR_RST;
    end else if (cmd.reload) begin
      est <= init_est;
      err <= init_err;
    end else if (cmd.update) begin
      est <= est_next;
      err <= err_next;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      meas <= sample.measured_speed;
      den  <= den_init;
      rem  <= DEN_W'(num >> (FRAC_BITS + 1));
      nlo  <= num[FRAC_BITS:0];
      quo  <= '0;
    end else if (cmd.div_step) begin
      nlo <= {nlo[FRAC_BITS-1:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial_sub[DEN_W-1:0];
        quo <= {quo[GAIN_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[GAIN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      gain_r <= gain_sel;
      pe     <= $signed({1'b0, gain_sel}) * diff;
      pr     <= (GAIN_ONE - gain_sel) * err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reload) begin
      result.estimated_speed <= init_est;
      result.gain            <= '0;
      result.error_estimate  <= init_err;
    end else if (cmd.update) begin
      result.estimated_speed <= est_next;
      result.gain            <= GAIN_OUT_W'(gain_r);
      result.error_estimate  <= err_next;
    end
  end

endmodule

// ----- design/scalar_kalman_speed_filter.sv -----
// channel  | direction | handshake                 | payload
// sample   | in        | sample_valid/sample_ready | measured_speed, restart
// result   | out       | result_valid/result_ready | estimated_speed, gain, error_estimate
// cfg      | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// one sample at a time; an update runs states DIV, MUL and UPD, a restart only RLD
// the gain divider (one quotient bit per cycle) sets the rate
// the next sample is taken while a result waits in the output register
// a stalled result holds the following one back at its last cycle
// synchronous reset loads the register defaults and the initial state; cfg is always ready
module scalar_kalman_speed_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  skf_pkg::sample_t              sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output skf_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skf_pkg::SPEED_W-1:0]   cfg_data
);
  import skf_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .restart      (sample.restart),
    .result_ready (result_ready),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  skf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    (sample),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

// ----- design/skf_chk.sv -----
`include "scalar_kalman_speed_filter_defines.svh"

module skf_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input skf_pkg::result_t              result
);
  import skf_pkg::*;

  `SKF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
                   result_valid && $stable(result), "stalled result changed")

  `SKF_ASSERT_NEXT(a_one_item, sample_valid && sample_ready, !sample_ready,
                   "second item taken while one is in work")

  `SKF_ASSERT_NOW(a_ready_after_result, $rose(result_valid), sample_ready,
                  "block not ready after issuing a result")

  `SKF_ASSERT_NOW(a_gain_range, result_valid,
                  result.gain <= GAIN_OUT_W'(GAIN_ONE), "gain above one")

endmodule

bind scalar_kalman_speed_filter skf_chk u_chk (.*);

// ----- sim/tb_scalar_kalman_speed_filter.sv -----
`timescale 1ns / 1ps

module tb_scalar_kalman_speed_filter;
  import skf_pkg::*;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     HOLD_AT      = 300;
  localparam int     HOLD_LEN     = 600;
  localparam int     QUIET_FROM   = 30000;
  localparam int     QUIET_TO     = 40000;
  localparam int     RAND_PHASES  = 6;
  localparam int     PHASE_ITEMS  = 325;
  localparam longint UNITY        = 64'sd1 <<< FRAC_BITS;
  localparam longint HALF_LSB     = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint SPEED_MAX    = 64'sd2147483647;
  localparam longint SPEED_MIN    = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_ready;
  sample_t                sample;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SPEED_W-1:0]     cfg_data;

  sample_t pending_samples[$];
  result_t expected_results[$];
  result_t want;

  logic [ERR_W-1:0]          meas_err_q;
  logic [ERR_W-1:0]          init_err_q;
  logic signed [SPEED_W-1:0] init_est_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [ERR_W-1:0]          err_q;

  int cycle_count;
  int mismatches;
  int results_seen;
  int hold_cycles;
  bit hold_done;

  scalar_kalman_speed_filter dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic result_t filter_step(sample_t s);
    result_t          r;
    longint unsigned  den;
    longint unsigned  g;
    longint unsigned  e;
    longint           diff;
    longint           nxt;
    g = 0;
    if (s.restart) begin
      speed_q = init_est_q;
      err_q   = init_err_q;
    end else begin
      den = longint'(err_q) + longint'(meas_err_q);
      if (den != 0) g = ((longint'(err_q) << FRAC_BITS) + (den >> 1)) / den;
      if (g > UNITY) g = UNITY;
      diff = longint'(s.measured_speed) - longint'(speed_q);
      nxt  = longint'(speed_q) + ((longint'(g) * diff + HALF_LSB) >>> FRAC_BITS);
      if (nxt > SPEED_MAX) nxt = SPEED_MAX;
      if (nxt < SPEED_MIN) nxt = SPEED_MIN;
      speed_q = nxt[SPEED_W-1:0];
      e = ((UNITY - g) * longint'(err_q) + HALF_LSB) >> FRAC_BITS;
      if (e > err_q) e = err_q;
      err_q = e[ERR_W-1:0];
    end
    r.estimated_speed = speed_q;
    r.gain            = g[GAIN_OUT_W-1:0];
    r.error_estimate  = err_q;
    return r;
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 21;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned exp_val);
    $display("mismatch %s at result %0d: got 0x%0h expected 0x%0h",
             field, results_seen, got, exp_val);
    mismatches++;
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) expected_results.push_back(filter_step(sample));
      if (!sample_valid || sample_ready) begin
        if (pending_samples.size() != 0 && !idle_now()) begin
          sample       <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_cycles <= HOLD_LEN;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", result.estimated_speed, 0);
        end else begin
          want = expected_results.pop_front();
          if (result.estimated_speed !== want.estimated_speed)
            report_mismatch("estimated_speed", result.estimated_speed, want.estimated_speed);
          if (result.gain !== want.gain)
            report_mismatch("gain", result.gain, want.gain);
          if (result.error_estimate !== want.error_estimate)
            report_mismatch("error_estimate", result.error_estimate, want.error_estimate);
        end
        results_seen++;
      end
      if (hold_cycles != 0) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= !idle_now();
      end
    end
  end

  task automatic add_sample(logic signed [SPEED_W-1:0] speed, logic restart);
    sample_t s;
    s.measured_speed = speed;
    s.restart        = restart;
    pending_samples.push_back(s);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPEED_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_MEAS_ERR: meas_err_q = data[ERR_W-1:0];
      CFG_INIT_ERR: init_err_q = data[ERR_W-1:0];
      CFG_INIT_EST: init_est_q = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_filter(logic [ERR_W-1:0] meas, logic [ERR_W-1:0] ierr,
                            logic [SPEED_W-1:0] iest);
    write_reg(CFG_MEAS_ERR, {8'($urandom), meas});
    write_reg(CFG_INIT_ERR, {8'($urandom), ierr});
    write_reg(CFG_INIT_EST, iest);
  endtask

  function automatic logic signed [SPEED_W-1:0] random_speed();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom;
    if (pick < 80) return $signed($urandom_range(2097151)) - 32'sd1048576;
    case ($urandom_range(4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    result_ready = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MEAS_ERR;
    cfg_data     = '0;
    cycle_count  = 0;
    mismatches   = 0;
    results_seen = 0;
    hold_cycles  = 0;
    hold_done    = 1'b0;
    meas_err_q   = MEAS_ERR_RST;
    init_err_q   = INIT_ERR_RST;
    init_est_q   = INIT_EST_RST;
    speed_q      = INIT_EST_RST;
    err_q        = INIT_ERR_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset
    add_sample(32'sd0, 1'b0);
    add_sample(32'sh7FFFFFFF, 1'b0);
    add_sample(32'sh80000000, 1'b0);
    add_sample(-32'sd1, 1'b0);
    add_sample(32'sd1, 1'b0);
    add_sample(32'sh7FFFFFFF, 1'b1);
    add_sample(32'sd65536, 1'b0);
    wait_drained();

    // gain of one, full-scale jumps
    set_filter(24'd1, 24'hFFFFFF, 32'sh7FFFFFFF);
    add_sample(32'sd0, 1'b1);
    add_sample(32'sh80000000, 1'b0);
    add_sample(32'sh7FFFFFFF, 1'b0);
    add_sample(32'sh80000000, 1'b0);
    wait_drained();

    // zero denominator
    set_filter(24'd0, 24'd0, 32'sh80000000);
    add_sample(32'sd12345, 1'b1);
    add_sample(32'sd12345, 1'b0);
    add_sample(32'sh7FFFFFFF, 1'b0);
    wait_drained();

    // tiny gain, unused register index
    set_filter(24'hFFFFFF, 24'd1, 32'sd0);
    write_reg(CFG_UNUSED, $urandom);
    add_sample(32'sd0, 1'b1);
    add_sample(32'sh7FFFFFFF, 1'b0);
    add_sample(32'sh80000000, 1'b0);
    add_sample(32'sh55555555, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_filter(MEAS_ERR_RST, INIT_ERR_RST, INIT_EST_RST);
        1: set_filter(24'hFFFFFF, 24'hFFFFFF, 32'sh80000000);
        2: set_filter(24'd1, 24'd1, 32'sh7FFFFFFF);
        3: set_filter(24'($urandom_range(5000, 1)), 24'($urandom), $urandom);
        default: set_filter(24'($urandom_range(24'hFFFFFF, 1)), 24'($urandom), $urandom);
      endcase
      add_sample(random_speed(), 1'b1);
      for (int i = 1; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_drained();
        add_sample(random_speed(), $urandom_range(99) < 6);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule
